/* rtl/deb_pkg.sv */
package deb_pkg;

    localparam int VOICES        = 32;
    // voice numbers are 5 bits wide, so at most 32 voices are served
    localparam int ACTIVE_VOICES = (VOICES > 32) ? 32 : VOICES;
    localparam int IDX_W         = (ACTIVE_VOICES > 1) ? $clog2(ACTIVE_VOICES) : 1;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [21:0] FULL_SCALE = 22'h200000;

    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_VOL_ATK = 3'd1;
    localparam logic [2:0] CMD_VOL_DEC = 3'd2;
    localparam logic [2:0] CMD_MOD_ATK = 3'd3;
    localparam logic [2:0] CMD_MOD_DEC = 3'd4;

    typedef enum logic [2:0] {
        PH_STOP    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ATTACK = 2'd1,
        OP_DECAY  = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic        env_mod;
        logic [4:0]  voice;
        logic [15:0] value;
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } push_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } pop_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_TICK = 1'b1
    } back_state_t;

    // rates and sustain are kept as the raw 7-bit register fields
    typedef struct packed {
        logic [21:0] level;
        phase_t      phase;
        logic [6:0]  atk;
        logic [6:0]  dec;
        logic [6:0]  rel;
        logic [6:0]  sus;
    } env_t;

    typedef struct packed {
        env_t vol;
        env_t mod;
    } row_t;

endpackage

/* rtl/deb_front.sv */
module deb_front
(
    input  logic           req_valid,
    output logic           req_stall,
    input  logic [2:0]     cmd,
    input  logic [4:0]     voice,
    input  logic [15:0]    value,
    input  logic           q_full,
    output deb_pkg::push_t push
);

    logic           legal;
    logic           voice_ok;
    deb_pkg::op_t   op;

    assign voice_ok = (6'(voice) < 6'(deb_pkg::ACTIVE_VOICES));

    always_comb
    begin
        op.voice   = voice;
        op.value   = value;
        op.kind    = deb_pkg::OP_TICK;
        op.env_mod = 1'b0;
        legal      = 1'b0;
        case (cmd)
            deb_pkg::CMD_TICK:
            begin
                legal = 1'b1;
            end
            deb_pkg::CMD_VOL_ATK:
            begin
                op.kind = deb_pkg::OP_ATTACK;
                legal   = voice_ok;
            end
            deb_pkg::CMD_VOL_DEC:
            begin
                op.kind = deb_pkg::OP_DECAY;
                legal   = voice_ok;
            end
            deb_pkg::CMD_MOD_ATK:
            begin
                op.kind    = deb_pkg::OP_ATTACK;
                op.env_mod = 1'b1;
                legal      = voice_ok;
            end
            deb_pkg::CMD_MOD_DEC:
            begin
                op.kind    = deb_pkg::OP_DECAY;
                op.env_mod = 1'b1;
                legal      = voice_ok;
            end
            default:
            begin
                legal = 1'b0;
            end
        endcase
    end

    // illegal items are taken and dropped
    assign req_stall  = q_full;
    assign push.valid = req_valid && !q_full && legal;
    assign push.op    = op;

endmodule

/* rtl/deb_queue.sv */
module deb_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  deb_pkg::push_t push,
    output logic           full,
    output deb_pkg::pop_t  head,
    input  logic           pop
);

    deb_pkg::op_t                    entry_reg [deb_pkg::QUEUE_DEPTH];
    logic [deb_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [deb_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [deb_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full       = (count_reg == deb_pkg::QCNT_W'(deb_pkg::QUEUE_DEPTH));
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.op    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == deb_pkg::QPTR_W'(deb_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == deb_pkg::QPTR_W'(deb_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.op;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= deb_pkg::QCNT_W'(deb_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

endmodule

/* rtl/deb_back.sv */
module deb_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  deb_pkg::pop_t head,
    output logic          pop,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output logic [4:0]    voice_index,
    output logic [21:0]   vol_level,
    output logic [2:0]    vol_phase,
    output logic [21:0]   mod_level,
    output logic [2:0]    mod_phase,
    output logic          last
);

    localparam logic [deb_pkg::IDX_W-1:0] LAST_IDX = deb_pkg::IDX_W'(deb_pkg::ACTIVE_VOICES - 1);

    function automatic deb_pkg::env_t env_step(input deb_pkg::env_t e);
        logic [22:0]   sum;
        logic [22:0]   floor_lvl;
        deb_pkg::env_t r;
        r         = e;
        sum       = {1'b0, e.level} + 23'({e.atk, 6'b0});
        floor_lvl = 23'({e.sus, 14'b0}) + 23'(e.dec);
        case (e.phase)
            deb_pkg::PH_ATTACK:
            begin
                if (sum >= 23'(deb_pkg::FULL_SCALE))
                begin
                    r.level = deb_pkg::FULL_SCALE;
                    r.phase = deb_pkg::PH_DECAY;
                end
                else
                begin
                    r.level = sum[21:0];
                end
            end
            deb_pkg::PH_DECAY:
            begin
                // land on sustain even when that raises the level
                if ({1'b0, e.level} <= floor_lvl)
                begin
                    r.level = 22'({e.sus, 14'b0});
                    r.phase = deb_pkg::PH_SUSTAIN;
                end
                else
                begin
                    r.level = e.level - 22'(e.dec);
                end
            end
            deb_pkg::PH_RELEASE:
            begin
                if (e.level <= 22'(e.rel))
                begin
                    r.level = '0;
                    r.phase = deb_pkg::PH_STOP;
                end
                else
                begin
                    r.level = e.level - 22'(e.rel);
                end
            end
            default:
            begin
                r = e;
            end
        endcase
        return r;
    endfunction

    function automatic deb_pkg::env_t env_write(input deb_pkg::env_t e,
                                                input deb_pkg::op_kind_t kind,
                                                input logic [15:0] w);
        deb_pkg::env_t r;
        r = e;
        if (kind == deb_pkg::OP_ATTACK)
        begin
            r.atk = w[6:0];
            if (!w[15])
            begin
                r.phase = deb_pkg::PH_ATTACK;
            end
        end
        else
        begin
            r.sus = w[14:8];
            if (w[15])
            begin
                r.phase = deb_pkg::PH_RELEASE;
                r.rel   = w[6:0];
            end
            else
            begin
                r.dec = w[6:0];
            end
            if (w[7])
            begin
                r.phase = deb_pkg::PH_STOP;
            end
        end
        return r;
    endfunction

    deb_pkg::row_t                 row_mem [deb_pkg::ACTIVE_VOICES];
    logic [deb_pkg::ACTIVE_VOICES-1:0] row_valid_reg, row_valid_next;

    deb_pkg::back_state_t          state_reg, state_next;
    logic [deb_pkg::IDX_W-1:0]     cnt_reg, cnt_next;

    logic                          rd_en;
    logic [deb_pkg::IDX_W-1:0]     rd_addr;
    deb_pkg::row_t                 rd_data_reg;
    logic                          rd_valid_reg;

    logic                          s1_valid_reg, s1_valid_next;
    logic                          s1_tick_reg, s1_tick_next;
    logic                          s1_last_reg, s1_last_next;
    logic [deb_pkg::IDX_W-1:0]     s1_addr_reg, s1_addr_next;
    deb_pkg::op_t                  s1_op_reg, s1_op_next;
    logic                          s1_adv;
    deb_pkg::row_t                 row_cur;
    deb_pkg::row_t                 row_new;

    logic                          rsp_valid_reg, rsp_valid_next;
    logic [4:0]                    voice_index_reg, voice_index_next;
    logic [21:0]                   vol_level_reg, vol_level_next;
    logic [2:0]                    vol_phase_reg, vol_phase_next;
    logic [21:0]                   mod_level_reg, mod_level_next;
    logic [2:0]                    mod_phase_reg, mod_phase_next;
    logic                          last_reg, last_next;

    // a tick result leaves stage 1 only when the output register can take it
    assign s1_adv = s1_valid_reg && (!s1_tick_reg || !rsp_valid_reg || !rsp_stall);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            deb_pkg::ST_IDLE:
            begin
                if (pop && head.op.kind == deb_pkg::OP_TICK)
                begin
                    state_next = deb_pkg::ST_TICK;
                end
            end
            deb_pkg::ST_TICK:
            begin
                if (rd_en && cnt_reg == LAST_IDX)
                begin
                    state_next = deb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = deb_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        pop     = 1'b0;
        rd_en   = 1'b0;
        rd_addr = cnt_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            deb_pkg::ST_IDLE:
            begin
                pop      = head.valid && !s1_valid_reg;
                rd_en    = pop && (head.op.kind != deb_pkg::OP_TICK);
                rd_addr  = head.op.voice[deb_pkg::IDX_W-1:0];
                cnt_next = pop ? '0 : cnt_reg;
            end
            deb_pkg::ST_TICK:
            begin
                rd_en = !s1_valid_reg || s1_adv;
                if (rd_en && cnt_reg != LAST_IDX)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        s1_valid_next = rd_en ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        s1_tick_next  = s1_tick_reg;
        s1_last_next  = s1_last_reg;
        s1_addr_next  = s1_addr_reg;
        s1_op_next    = s1_op_reg;
        if (rd_en)
        begin
            s1_tick_next = (state_reg == deb_pkg::ST_TICK);
            s1_last_next = (cnt_reg == LAST_IDX);
            s1_addr_next = rd_addr;
            s1_op_next   = head.op;
        end
    end

    // never-written rows read as the reset state
    assign row_cur = rd_valid_reg ? rd_data_reg : '0;

    always_comb
    begin
        row_new = row_cur;
        if (s1_tick_reg)
        begin
            row_new.vol = env_step(row_cur.vol);
            row_new.mod = env_step(row_cur.mod);
        end
        else if (s1_op_reg.env_mod)
        begin
            row_new.mod = env_write(row_cur.mod, s1_op_reg.kind, s1_op_reg.value);
        end
        else
        begin
            row_new.vol = env_write(row_cur.vol, s1_op_reg.kind, s1_op_reg.value);
        end
    end

    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (s1_adv)
        begin
            row_valid_next[s1_addr_reg] = 1'b1;
        end
    end

    always_comb
    begin
        rsp_valid_next   = rsp_stall ? rsp_valid_reg : 1'b0;
        voice_index_next = voice_index_reg;
        vol_level_next   = vol_level_reg;
        vol_phase_next   = vol_phase_reg;
        mod_level_next   = mod_level_reg;
        mod_phase_next   = mod_phase_reg;
        last_next        = last_reg;
        if (s1_adv && s1_tick_reg)
        begin
            rsp_valid_next   = 1'b1;
            voice_index_next = 5'(s1_addr_reg);
            vol_level_next   = row_cur.vol.level;
            vol_phase_next   = row_cur.vol.phase;
            mod_level_next   = row_cur.mod.level;
            mod_phase_next   = row_cur.mod.phase;
            last_next        = s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= deb_pkg::ST_IDLE;
            cnt_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            row_valid_reg <= row_valid_next;
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tick_reg     <= s1_tick_next;
        s1_last_reg     <= s1_last_next;
        s1_addr_reg     <= s1_addr_next;
        s1_op_reg       <= s1_op_next;
        voice_index_reg <= voice_index_next;
        vol_level_reg   <= vol_level_next;
        vol_phase_reg   <= vol_phase_next;
        mod_level_reg   <= mod_level_next;
        mod_phase_reg   <= mod_phase_next;
        last_reg        <= last_next;
    end

    // envelope memory: one write-back port, one registered read port
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            row_mem[s1_addr_reg] <= row_new;
        end
        if (rd_en)
        begin
            rd_data_reg <= row_mem[rd_addr];
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign voice_index = voice_index_reg;
    assign vol_level   = vol_level_reg;
    assign vol_phase   = vol_phase_reg;
    assign mod_level   = mod_level_reg;
    assign mod_phase   = mod_phase_reg;
    assign last        = last_reg;

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && rd_en) |-> (s1_addr_reg != rd_addr))
        else $error("read and write-back hit the same row");

    a_last_voice: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && last_reg) |-> (voice_index_reg == 5'(LAST_IDX)))
        else $error("last flag on wrong voice");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_addr_reg)))
        else $error("stalled stage 1 lost its voice");

endmodule

/* rtl/dual_envelope_bank.sv */
// Two envelope generators (volume and modulation) for each of 32 voices.
// Request channel (req_valid/req_stall, fields cmd, voice, value): a transfer
// with cmd 1..4 writes an attack or decay/sustain word for one envelope of one
// voice; cmd 0 is a tick that steps every envelope once. Unused commands and
// writes to voices out of range are taken and dropped.
// Result channel (rsp_valid/rsp_stall): a tick gives one transfer per voice,
// in voice order, with both levels and phases before that tick's update;
// last marks the final voice. Writes give no result.
// Requests pass through a two-entry queue to a sequencer that, during a
// tick, reads one row of the envelope memory per cycle unless the receiver
// stalls, holds it in stage 1 and writes it back from there. A tick holds the
// sequencer while it takes the tick from the queue, reads each voice in turn
// and writes back the last voice; a write, while it reads and writes one row.
// req_stall rises only while the queue is full.
// When the receiver stalls, the output register holds and the sequencer
// halts on the voice it has read; no result is lost.
// Reset clears every level, phase, rate and sustain to zero (all stopped).
module dual_envelope_bank
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [2:0]  cmd,
    input  logic [4:0]  voice,
    input  logic [15:0] value,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [4:0]  voice_index,
    output logic [21:0] vol_level,
    output logic [2:0]  vol_phase,
    output logic [21:0] mod_level,
    output logic [2:0]  mod_phase,
    output logic        last
);

    deb_pkg::push_t push;
    deb_pkg::pop_t  head;
    logic           q_full;
    logic           pop;

    deb_front u_front
    (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .voice     (voice),
        .value     (value),
        .q_full    (q_full),
        .push      (push)
    );

    deb_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .head  (head),
        .pop   (pop)
    );

    deb_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .voice_index (voice_index),
        .vol_level   (vol_level),
        .vol_phase   (vol_phase),
        .mod_level   (mod_level),
        .mod_phase   (mod_phase),
        .last        (last)
    );

endmodule
